// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/trb_pkg.sv
// Types, codes and helper functions of the two-bit reference count bitmap.
`default_nettype none

package trb_pkg;

	localparam int unsigned COUNTS_PER_WORD = 32;
	localparam int unsigned WORD_SHIFT      = 5;
	localparam int unsigned WORD_BITS       = 64;
	localparam int unsigned IDX_W           = 14;
	localparam int unsigned END_W           = 15;
	localparam int unsigned IDX_SPAN        = 16384;

	localparam logic [WORD_BITS-1:0] ODD_BITS  = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [WORD_BITS-1:0] EVEN_BITS = ~ODD_BITS;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_FIND   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DATA
	} state_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] entry_index;
		logic [1:0]       new_value;
		logic [END_W-1:0] range_end;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       entry_value;
		logic [IDX_W-1:0] free_position;
		logic             status;
	} res_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] pos;
	} first_t;

	// One bit per entry, set where both count bits are zero.
	function automatic logic [COUNTS_PER_WORD-1:0] free_mask(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0]       nz;
		logic [COUNTS_PER_WORD-1:0] m;
		nz = (w | (w >> 1)) & EVEN_BITS;
		for (int k = 0; k < COUNTS_PER_WORD; k++) begin
			m[k] = ~nz[2*k];
		end
		return m;
	endfunction

	// Lowest set bit of a 32-bit mask.
	function automatic first_t first_one(input logic [COUNTS_PER_WORD-1:0] m);
		first_t r;
		r.hit = |m;
		r.pos = '0;
		for (int k = COUNTS_PER_WORD - 1; k >= 0; k--) begin
			if (m[k]) begin
				r.pos = 5'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trb_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/two_bit_refcount_bitmap.sv
// Top level of the two-bit reference count bitmap: sequencer, search unit and word store.
// A store of NUM_ENTRIES two-bit counts, 32 to a 64-bit RAM word (entry k: high bit at
// 2k, low bit at 2k+1). After reset the block sweeps the RAM to zero, one word a cycle,
// with busy high. A command beat is taken when start is high and busy is low; every
// command gives exactly one result beat, shown on result for the single cycle that done
// is high, and the receiver cannot stall it. Lookup and set read the RAM word as the
// command is accepted, then decode or write it back in the data state; the result is
// registered and appears in the cycle after that state. Find visits the 64-bit words in
// order, from the word holding entry_index to the one holding the first free entry or
// the clamped range end, then returns to idle. No new command is taken until the block
// is back in idle. The pace of find is set by the single RAM read port, which the search
// unit uses once per word. Lookups past the store answer zero, sets past it are dropped,
// and range_end is clamped to the store.
`default_nettype none
`include "assert_macros.svh"

module two_bit_refcount_bitmap #(
	parameter int unsigned NUM_ENTRIES = 16384
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire trb_pkg::cmd_t cmd,
	output logic               done,
	output trb_pkg::res_t      result
);

	import trb_pkg::*;

	localparam int unsigned STORE_WORDS = (NUM_ENTRIES + COUNTS_PER_WORD - 1) / COUNTS_PER_WORD;
	localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int unsigned END_CAP     = (NUM_ENTRIES < IDX_SPAN) ? NUM_ENTRIES : IDX_SPAN;

	// sequencer state
	state_t state_q, state_d;

	// per-command registers
	cmd_t             op_q;
	logic [END_W-1:0] cur_q, cur_d;     // entry cursor; word part addresses the RAM
	logic [END_W-1:0] end_q;            // clamped exclusive range end
	logic             in_range_q;
	logic [AW-1:0]    clr_q;

	// result beat
	logic done_d;
	res_t res_d;

	// RAM port
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	// search unit and word decode
	logic [END_W-1:0]           next_base;
	logic [END_W-1:0]           hit_pos;
	logic [COUNTS_PER_WORD-1:0] search_mask;
	first_t                     first;
	logic [4:0]                 off;
	logic [5:0]                 bit_lo;
	logic [WORD_BITS-1:0]       set_mask, set_bits;
	logic [31:0]                cur_word, cmd_word, next_word;
	logic                       accept;
	logic [END_W-1:0]           end_clamped;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// word addresses, widened then cut to the RAM address width
	assign cur_word  = 32'(cur_q[END_W-1:WORD_SHIFT]);
	assign cmd_word  = 32'(cmd.entry_index[IDX_W-1:WORD_SHIFT]);
	assign next_base = {cur_q[END_W-1:WORD_SHIFT] + 10'd1, 5'd0};
	assign next_word = 32'(next_base[END_W-1:WORD_SHIFT]);

	assign end_clamped = (32'(cmd.range_end) > END_CAP) ? END_W'(END_CAP) : cmd.range_end;

	// entry decode within the current word
	assign off      = cur_q[WORD_SHIFT-1:0];
	assign bit_lo   = {off, 1'b0};
	assign set_mask = WORD_BITS'(2'b11) << bit_lo;
	assign set_bits = WORD_BITS'({op_q.new_value[0], op_q.new_value[1]}) << bit_lo;

	// first free entry at or above the cursor within this word
	assign search_mask = free_mask(ram_rdata) & ({COUNTS_PER_WORD{1'b1}} << off);
	assign first       = first_one(search_mask);
	assign hit_pos     = {cur_q[END_W-1:WORD_SHIFT], first.pos};

	trb_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		done_d    = 1'b0;
		res_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = cur_word[AW-1:0];
		ram_wdata = (ram_rdata & ~set_mask) | set_bits;
		ram_raddr = cur_word[AW-1:0];

		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(STORE_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// read ahead the word of the incoming command
				ram_raddr = cmd_word[AW-1:0];
				if (accept) begin
					cur_d   = END_W'(cmd.entry_index);
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				unique case (op_q.func)
					FUNC_LOOKUP: begin
						if (in_range_q) begin
							res_d.entry_value = {ram_rdata[bit_lo], ram_rdata[{off, 1'b1}]};
						end
					end
					FUNC_SET: begin
						ram_we = in_range_q;
					end
					FUNC_FIND: begin
						if (cur_q >= end_q) begin
							res_d.status = 1'b1;
						end else if (first.hit && (hit_pos < end_q)) begin
							res_d.free_position = hit_pos[IDX_W-1:0];
						end else if (first.hit || (next_base >= end_q)) begin
							res_d.status = 1'b1;
						end else begin
							// whole rest of this word in use: move on to the next one
							done_d    = 1'b0;
							state_d   = ST_DATA;
							cur_d     = next_base;
							ram_raddr = next_word[AW-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			done  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			done <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		result <= res_d;
		if (accept) begin
			op_q       <= cmd;
			end_q      <= end_clamped;
			in_range_q <= (32'(cmd.entry_index) < NUM_ENTRIES);
		end
	end

	// a result beat only ever leaves as the sequencer returns to idle
	`ASSERT_PROP(a_done_idle, clk, arst_n, done |-> state_q == ST_IDLE)
	// while a find walks the store the cursor only moves forward
	`ASSERT_PROP(a_cursor_fwd, clk, arst_n, (state_q == ST_DATA && $past(state_q) == ST_DATA) |-> cur_q > $past(cur_q))
	// the clearing pass ends only after its last word
	`ASSERT_PROP(a_clear_end, clk, arst_n, (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> $past(clr_q) == AW'(STORE_WORDS - 1))

endmodule

`default_nettype wire
